>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the minimum path sum unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked also while reset is high
`define GMPS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("gmps: check failed");

// next-cycle check, off during reset
`define GMPS_ASSERT_NEXT_ON(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gmps: check failed");

// same-cycle check, off during reset
`define GMPS_ASSERT_NOW_ON(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gmps: check failed");

`endif

>>> rtl/core/gmps_pkg.sv
// ----------------------------------------------------------------------------
// gmps_pkg
// shared types and constants of the minimum path sum unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmps_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam int COST_W     = 16;
  localparam int SUM_W      = 32;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam int MID_DEPTH  = 4;
  localparam int OUT_DEPTH  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;

  // classification of one cell, front to back
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic one_col;
    logic last;
  } cell_flags_t;

  localparam int FLAGS_W = $bits(cell_flags_t);

endpackage

>>> rtl/core/gmps_ram.sv
// ----------------------------------------------------------------------------
// gmps_ram
// generic one-write one-read ram with registered read, old data on collision
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/gmps_fifo.sv
// ----------------------------------------------------------------------------
// gmps_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/gmps_front.sv
// ----------------------------------------------------------------------------
// gmps_front
// grid size registers, raster position and per-cell classification
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmps_front import gmps_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        accept,
  output logic [$clog2(MAX_COLS)-1:0] cell_col,
  output cell_flags_t                 cell_flags
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [AW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic [31:0]   cfg_v;
  logic [AW-1:0] last_col_next;
  logic [RW-1:0] last_row_next;

  assign cfg_v = 32'(cfg_data);

  // size zero reads as one, oversize saturates
  always_comb begin
    if (cfg_v == 32'd0) begin
      last_col_next = '0;
      last_row_next = '0;
    end else begin
      if (cfg_v > 32'(MAX_COLS)) begin
        last_col_next = AW'(MAX_COLS - 1);
      end else begin
        last_col_next = AW'(cfg_v - 32'd1);
      end
      if (cfg_v > 32'(MAX_ROWS)) begin
        last_row_next = RW'(MAX_ROWS - 1);
      end else begin
        last_row_next = RW'(cfg_v - 32'd1);
      end
    end
  end

  assign cell_col             = col;
  assign cell_flags.first_row = (row == '0);
  assign cell_flags.first_col = (col == '0);
  assign cell_flags.one_col   = (last_col == '0);
  assign cell_flags.last      = (col == last_col) && (row == last_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      last_col <= '0;
      last_row <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_COLS: begin
          last_col <= last_col_next;
          col      <= '0;
          row      <= '0;
        end
        REG_GRID_ROWS: begin
          last_row <= last_row_next;
          col      <= '0;
          row      <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col == last_col) begin
        col <= '0;
        row <= cell_flags.last ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/gmps_back.sv
// ----------------------------------------------------------------------------
// gmps_back
// row buffer read, min and saturating add, row buffer write back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmps_back import gmps_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  logic [COST_W-1:0]                   q_cost,
  input  logic [$clog2(MAX_COLS)-1:0]         q_col,
  input  cell_flags_t                         q_flags,
  output logic                                q_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]      out_count,
  output logic                                out_push,
  output logic [SUM_W-1:0]                    out_sum,
  output logic                                out_final
);

  localparam int AW  = $clog2(MAX_COLS);
  localparam int OCW = $clog2(OUT_DEPTH + 1) + 1;

  logic              ex_valid;
  logic [COST_W-1:0] ex_cost;
  logic [AW-1:0]     ex_col;
  cell_flags_t       ex_flags;
  logic [SUM_W-1:0]  left_sum;
  logic [SUM_W-1:0]  ram_q;
  logic [SUM_W-1:0]  above;
  logic [SUM_W-1:0]  base;
  logic [SUM_W:0]    raw;
  logic [SUM_W-1:0]  sum;

  // only issue when the result queue has a free slot for it
  assign q_pop = !q_empty &&
                 ((OCW'(out_count) + OCW'(ex_valid)) < OCW'(OUT_DEPTH));

  gmps_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_COLS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ex_valid),
    .waddr (ex_col),
    .wdata (sum),
    .re    (q_pop),
    .raddr (q_col),
    .rdata (ram_q)
  );

  // one column: the cell above is the previous word
  assign above = ex_flags.one_col ? left_sum : ram_q;

  always_comb begin
    if (ex_flags.first_row && ex_flags.first_col) begin
      base = '0;
    end else if (ex_flags.first_row) begin
      base = left_sum;
    end else if (ex_flags.first_col) begin
      base = above;
    end else begin
      base = (above < left_sum) ? above : left_sum;
    end
    raw = {1'b0, base} + (SUM_W + 1)'(ex_cost);
    sum = raw[SUM_W] ? '1 : raw[SUM_W-1:0];
  end

  assign out_push  = ex_valid;
  assign out_sum   = sum;
  assign out_final = ex_flags.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else begin
      ex_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ex_cost  <= q_cost;
      ex_col   <= q_col;
      ex_flags <= q_flags;
    end
    if (ex_valid) begin
      left_sum <= sum;
    end
  end

endmodule

>>> rtl/core/grid_min_path_sum_unit.sv
// ----------------------------------------------------------------------------
// grid_min_path_sum_unit
// streaming minimum path sum over a raster-ordered cost grid
//
//   channel   handshake          payload
//   input     push / full        cell_cost
//   result    empty / pop        cell_sum, is_final
//   config    cfg_valid / ready  cfg_index, cfg_data
//
// one cell per cycle sustained while the result side keeps up; a taken word
// passes the command queue, the row buffer read and add stage, and the result queue
// synchronous reset empties both queues and restarts at the top-left cell
// the row buffer holds no reset; row zero writes each column before use
// a stalled result side backs up through a four-word command queue to full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_min_path_sum_unit import gmps_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [COST_W-1:0]     cell_cost,
  output logic                  empty,
  input  logic                  pop,
  output logic [SUM_W-1:0]      cell_sum,
  output logic                  is_final,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(MAX_COLS);
  localparam int MID_W = COST_W + AW + FLAGS_W;
  localparam int OUT_W = SUM_W + 1;

  logic                           accept;
  logic [AW-1:0]                  front_col;
  cell_flags_t                    front_flags;
  logic [MID_W-1:0]               mid_dout;
  logic                           mid_empty;
  logic                           mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic [COST_W-1:0]              q_cost;
  logic [AW-1:0]                  q_col;
  cell_flags_t                    q_flags;
  logic                           out_push;
  logic [SUM_W-1:0]               out_sum;
  logic                           out_final;
  logic                           out_full;
  logic [OUT_W-1:0]               out_dout;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  gmps_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .cell_col   (front_col),
    .cell_flags (front_flags)
  );

  gmps_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   ({cell_cost, front_col, front_flags}),
    .full  (full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign {q_cost, q_col, q_flags} = mid_dout;

  gmps_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (mid_empty || (mid_count == '0)),
    .q_cost    (q_cost),
    .q_col     (q_col),
    .q_flags   (q_flags),
    .q_pop     (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_sum   (out_sum),
    .out_final (out_final)
  );

  gmps_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push && !out_full),
    .din   ({out_sum, out_final}),
    .full  (out_full),
    .pop   (pop && !empty),
    .dout  (out_dout),
    .empty (empty),
    .count (out_count)
  );

  assign {cell_sum, is_final} = out_dout;

endmodule

>>> rtl/core/gmps_checker.sv
// ----------------------------------------------------------------------------
// gmps_checker
// port-level checks of the minimum path sum unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gmps_checker import gmps_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [SUM_W-1:0] cell_sum,
  input logic             is_final
);

  localparam int MAX_PENDING = MID_DEPTH + 1 + OUT_DEPTH;

  logic       in_acc;
  logic       out_acc;
  logic [7:0] pending;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  // words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  `GMPS_ASSERT_NEXT(a_rst_empty, rst, empty && !full)
  `GMPS_ASSERT_NEXT_ON(a_hold, !empty && !pop, !empty && $stable(cell_sum) && $stable(is_final))
  `GMPS_ASSERT_NOW_ON(a_no_invent, !empty, pending != 8'd0)
  `GMPS_ASSERT_NOW_ON(a_bounded, 1'b1, pending <= 8'(MAX_PENDING))

endmodule

bind grid_min_path_sum_unit gmps_checker u_gmps_checker (.*);
